[hdl/psa_pkg.sv]
// ----------------------------------------------------------------------------
// psa_pkg - shared types and constants of the pool slot allocator
// Configuration and result structs, FSM states, command and register codes,
// and the small helpers used by the allocation datapath.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int unsigned SLOT_W     = 8;   // slot index on the ports
  localparam int unsigned GEN_W      = 7;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned EB_W       = 16;
  localparam int unsigned IDX_W      = 9;   // search index, as wide as slots_in_use
  localparam int unsigned CNT_W      = 9;
  localparam int unsigned MAP_BITS   = 32;  // free marks per map word
  localparam int unsigned MAP_SHIFT  = 5;
  localparam int unsigned WORD_IDX_W = IDX_W - MAP_SHIFT;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned REG_IDX_W  = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_SLOTS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ENTRY = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BASE  = 2'd2;

  localparam logic [IDX_W-1:0]  SLOTS_RESET = 9'd256;
  localparam logic [EB_W-1:0]   ENTRY_RESET = 16'd16;
  localparam logic [ADDR_W-1:0] BASE_RESET  = 32'd0;
  localparam logic [IDX_W-1:0]  LAST_RESET  = 9'h0FF;
  localparam logic [CNT_W-1:0]  COUNT_MAX   = 9'h1FF;
  localparam logic [GEN_W-1:0]  GEN_MASK    = 7'h7F;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_ALLOC,
    ST_FREE,
    ST_FULL
  } state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  slots_in_use;
    logic [EB_W-1:0]   entry_bytes;
    logic [ADDR_W-1:0] base_address;
  } cfg_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [GEN_W-1:0]  generation;
    logic [ADDR_W-1:0] address;
    logic              full_res;
    logic              bad_free;
    logic [CNT_W-1:0]  used_count;
  } res_t;

  // lowest set bit of a map word
  function automatic logic [MAP_SHIFT-1:0] first_set(input logic [MAP_BITS-1:0] v);
    logic [MAP_SHIFT-1:0] pos;
    pos = '0;
    for (int i = MAP_BITS - 1; i >= 0; i--) begin
      if (v[i]) begin
        pos = MAP_SHIFT'(i);
      end
    end
    return pos;
  endfunction

  // generation advance: wraps past the top value back to one, never zero
  function automatic logic [GEN_W-1:0] next_gen(input logic [GEN_W-1:0] g);
    logic [GEN_W-1:0] n;
    n = (g + GEN_W'(1)) & GEN_MASK;
    if (n <= GEN_W'(1)) begin
      n = GEN_W'(1);
    end
    return n;
  endfunction

endpackage

[hdl/psa_ram.sv]
// ----------------------------------------------------------------------------
// psa_ram - generic simple dual-port RAM
// One write port, one read port, read data registered and held while the
// read enable is low.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hdl/psa_regs.sv]
// ----------------------------------------------------------------------------
// psa_regs - configuration register file
// APB-style access to slots_in_use, entry_bytes and base_address.
// ----------------------------------------------------------------------------
module psa_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psa_pkg::PADDR_W-1:0]  paddr,
  input  logic [psa_pkg::PDATA_W-1:0]  pwdata,
  output logic [psa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output psa_pkg::cfg_t                cfg_o
);
  import psa_pkg::*;

  cfg_t                 cfg_q, cfg_d;
  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_SLOTS: cfg_d.slots_in_use = pwdata[IDX_W-1:0];
        REG_ENTRY: cfg_d.entry_bytes  = pwdata[EB_W-1:0];
        REG_BASE:  cfg_d.base_address = pwdata[ADDR_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SLOTS: prdata = PDATA_W'(cfg_q.slots_in_use);
      REG_ENTRY: prdata = PDATA_W'(cfg_q.entry_bytes);
      REG_BASE:  prdata = PDATA_W'(cfg_q.base_address);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slots_in_use <= SLOTS_RESET;
      cfg_q.entry_bytes  <= ENTRY_RESET;
      cfg_q.base_address <= BASE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/psa_ctrl.sv]
// ----------------------------------------------------------------------------
// psa_ctrl - allocation sequencer around the free-mark and generation RAMs
// Scans the packed free-mark map one word per cycle, then read-modify-writes
// the chosen slot's generation and map word.
// ----------------------------------------------------------------------------
module psa_ctrl #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  psa_pkg::cfg_t               cfg_i,
  input  logic [psa_pkg::IDX_W-1:0]   n_i,
  input  logic                        in_valid_i,
  input  logic                        cmd_i,
  input  logic [psa_pkg::SLOT_W-1:0]  slot_index_i,
  output logic                        in_stall_o,
  input  logic                        room_i,
  output logic                        res_load_o,
  output psa_pkg::res_t               res_o
);
  import psa_pkg::*;

  localparam int unsigned NWORDS = (POOL_SLOTS + MAP_BITS - 1) / MAP_BITS;
  localparam int unsigned MAW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned GAW    = $clog2(POOL_SLOTS);

  state_e                 state_q, state_d;
  logic [GAW-1:0]         clr_q, clr_d;
  logic [IDX_W-1:0]       st_q, st_d;
  logic [WORD_IDX_W-1:0]  wd_q, wd_d;
  logic                   wrap_q, wrap_d;
  logic [IDX_W-1:0]       s_q, s_d;
  logic [IDX_W-1:0]       last_q, last_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic                   map_we, map_re;
  logic [MAW-1:0]         map_waddr, map_raddr;
  logic [MAP_BITS-1:0]    map_wdata, map_rdata;
  logic                   gen_we, gen_re;
  logic [GAW-1:0]         gen_waddr, gen_raddr;
  logic [GEN_W-1:0]       gen_wdata, gen_rdata;

  logic [IDX_W-1:0]       st_calc, nm1, hit_slot;
  logic [WORD_IDX_W-1:0]  lw, st_word, wd_next;
  logic [MAP_SHIFT-1:0]   lb, st_bit, pos;
  logic [MAP_BITS-1:0]    mask, cand, bit_one;
  logic                   found, exhausted, bit_sel, free_bad, in_pool, clr_last;
  logic [GEN_W-1:0]       gen_new;
  logic [IDX_W+EB_W-1:0]  prod;
  logic [ADDR_W-1:0]      addr_calc;

  psa_ram #(.WIDTH(MAP_BITS), .DEPTH(NWORDS), .AW(MAW)) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  psa_ram #(.WIDTH(GEN_W), .DEPTH(POOL_SLOTS), .AW(GAW)) u_gen_ram (
    .clk_i   (clk_i),
    .we_i    (gen_we),
    .waddr_i (gen_waddr),
    .wdata_i (gen_wdata),
    .re_i    (gen_re),
    .raddr_i (gen_raddr),
    .rdata_o (gen_rdata)
  );

  // search geometry and word evaluation
  always_comb begin
    st_calc = '0;
    if (last_q < n_i) begin
      st_calc = last_q + IDX_W'(1);
    end
    if (st_calc >= n_i) begin
      st_calc = '0;
    end
    nm1     = n_i - IDX_W'(1);
    lw      = nm1[IDX_W-1:MAP_SHIFT];
    lb      = nm1[MAP_SHIFT-1:0];
    st_word = st_q[IDX_W-1:MAP_SHIFT];
    st_bit  = st_q[MAP_SHIFT-1:0];
    for (int b = 0; b < MAP_BITS; b++) begin
      mask[b] = 1'b1;
      if (wd_q == lw && MAP_SHIFT'(b) > lb) begin
        mask[b] = 1'b0;
      end
      if (wd_q == st_word) begin
        if (wrap_q) begin
          if (MAP_SHIFT'(b) >= st_bit) mask[b] = 1'b0;
        end else begin
          if (MAP_SHIFT'(b) < st_bit) mask[b] = 1'b0;
        end
      end
    end
    cand      = map_rdata & mask;
    found     = |cand;
    pos       = first_set(cand);
    hit_slot  = {wd_q, pos};
    wd_next   = (wd_q == lw) ? '0 : wd_q + WORD_IDX_W'(1);
    exhausted = wrap_q && (wd_q == st_word);
    bit_one   = MAP_BITS'(1) << s_q[MAP_SHIFT-1:0];
    bit_sel   = map_rdata[s_q[MAP_SHIFT-1:0]];
    free_bad  = (s_q >= n_i) || bit_sel;
    in_pool   = 32'(s_q) < POOL_SLOTS;
    gen_new   = next_gen(gen_rdata);
    prod      = s_q * cfg_i.entry_bytes;
    addr_calc = cfg_i.base_address + ADDR_W'(prod);
    clr_last  = (clr_q == GAW'(POOL_SLOTS - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (cmd_i == CMD_FREE) ? ST_FREE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_d = ST_ALLOC;
        end else if (exhausted) begin
          state_d = ST_FULL;
        end
      end
      ST_ALLOC, ST_FREE, ST_FULL: if (room_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // bookkeeping registers
  always_comb begin
    clr_d   = clr_q;
    st_d    = st_q;
    wd_d    = wd_q;
    wrap_d  = wrap_q;
    s_d     = s_q;
    last_d  = last_q;
    count_d = count_q;
    case (state_q)
      ST_CLEAR: clr_d = clr_q + GAW'(1);
      ST_IDLE: begin
        if (in_valid_i) begin
          s_d    = IDX_W'(slot_index_i);
          st_d   = st_calc;
          wd_d   = st_calc[IDX_W-1:MAP_SHIFT];
          wrap_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (found) begin
          s_d = hit_slot;
        end else begin
          wd_d = wd_next;
          if (wd_next == st_word) wrap_d = 1'b1;
        end
      end
      ST_ALLOC: begin
        if (room_i) begin
          last_d = s_q;
          if (count_q != COUNT_MAX) count_d = count_q + CNT_W'(1);
        end
      end
      ST_FREE: begin
        if (room_i && !free_bad && count_q != '0) begin
          count_d = count_q - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // RAM controls, handshake and result
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    map_we     = 1'b0;
    map_waddr  = MAW'(s_q[IDX_W-1:MAP_SHIFT]);
    map_wdata  = map_rdata;
    map_re     = 1'b0;
    map_raddr  = MAW'(wd_next);
    gen_we     = 1'b0;
    gen_waddr  = GAW'(s_q);
    gen_wdata  = gen_new;
    gen_re     = 1'b0;
    gen_raddr  = GAW'(hit_slot);
    res_load_o = 1'b0;
    res_o.slot       = s_q[SLOT_W-1:0];
    res_o.generation = '0;
    res_o.address    = addr_calc;
    res_o.full_res   = 1'b0;
    res_o.bad_free   = 1'b0;
    res_o.used_count = count_d;
    case (state_q)
      ST_CLEAR: begin
        map_we    = 32'(clr_q) < NWORDS;
        map_waddr = MAW'(clr_q);
        map_wdata = '1;
        gen_we    = 1'b1;
        gen_waddr = clr_q;
        gen_wdata = '0;
      end
      ST_IDLE: begin
        map_re = in_valid_i;
        if (cmd_i == CMD_FREE) begin
          map_raddr = MAW'(slot_index_i[SLOT_W-1:MAP_SHIFT]);
        end else begin
          map_raddr = MAW'(st_calc[IDX_W-1:MAP_SHIFT]);
        end
        gen_re    = in_valid_i && (cmd_i == CMD_FREE);
        gen_raddr = GAW'(slot_index_i);
      end
      ST_SCAN: begin
        gen_re = found;
        map_re = !found && !exhausted;
      end
      ST_ALLOC: begin
        res_o.generation = gen_new;
        if (room_i) begin
          res_load_o = 1'b1;
          gen_we     = 1'b1;
          map_we     = 1'b1;
          map_wdata  = map_rdata & ~bit_one;
        end
      end
      ST_FREE: begin
        res_o.generation = in_pool ? gen_rdata : '0;
        res_o.bad_free   = free_bad;
        if (room_i) begin
          res_load_o = 1'b1;
          map_we     = !free_bad;
          map_wdata  = map_rdata | bit_one;
        end
      end
      ST_FULL: begin
        res_o.slot     = '0;
        res_o.address  = '0;
        res_o.full_res = 1'b1;
        res_load_o     = room_i;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      last_q  <= LAST_RESET;
      count_q <= '0;
      wrap_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      last_q  <= last_d;
      count_q <= count_d;
      wrap_q  <= wrap_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
    wd_q <= wd_d;
    s_q  <= s_d;
  end

endmodule

[hdl/pool_slot_allocator.sv]
// ----------------------------------------------------------------------------
// pool_slot_allocator - next-fit object pool allocator with slot generations
// Usage: send a transaction with cmd_i = 0 to allocate, or cmd_i = 1 with
// slot_index_i to free. Each transaction yields one result transaction with
// the slot, its generation, its byte address and the used count.
// Channels: valid/stall on both sides; a transaction moves when valid is high
// and stall is low. Configuration goes through the APB-style port; the user
// must write it only while the block is idle; the block itself does not enforce it.
// Sequence: a free goes from idle to the free state, which loads the result
// register; an allocate goes through the scan state, reading one 32-slot word
// of the free-mark map at a time from the search origin, then the allocate
// state, which loads the result; a full pool ends in the full state once the
// scan revisits its start word. One transaction is in flight at a time and
// the next is accepted once the sequencer is back in idle after the result
// loads; the previous result may still sit in the output register meanwhile.
// Reset: a clearing pass writes every entry of the map and generation RAMs;
// input stays stalled meanwhile, configuration writes still land.
// Receiver stall: the result holds in the output register, and a finished
// transaction waits in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module pool_slot_allocator #(
  parameter int unsigned POOL_SLOTS = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [psa_pkg::PADDR_W-1:0]  paddr,
  input  logic [psa_pkg::PDATA_W-1:0]  pwdata,
  output logic [psa_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         cmd_i,
  input  logic [psa_pkg::SLOT_W-1:0]   slot_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [psa_pkg::SLOT_W-1:0]   slot_o,
  output logic [psa_pkg::GEN_W-1:0]    generation_o,
  output logic [psa_pkg::ADDR_W-1:0]   address_o,
  output logic                         full_res_o,
  output logic                         bad_free_o,
  output logic [psa_pkg::CNT_W-1:0]    used_count_o
);
  import psa_pkg::*;

  cfg_t             cfg;
  logic [IDX_W-1:0] su_clamp, n_act;
  logic             room, res_load;
  res_t             res_d, res_q;
  logic             out_valid_q, out_valid_d;

  psa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Active slot count: zero acts as one, anything past the built pool
  // acts as the pool depth.
  always_comb begin
    su_clamp = (cfg.slots_in_use == '0) ? IDX_W'(1) : cfg.slots_in_use;
    n_act    = (32'(su_clamp) > POOL_SLOTS) ? IDX_W'(POOL_SLOTS) : su_clamp;
  end

  // The output register may take a new result when empty or draining.
  assign room = !out_valid_q || !out_stall_i;

  psa_ctrl #(.POOL_SLOTS(POOL_SLOTS)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .n_i          (n_act),
    .in_valid_i   (in_valid_i),
    .cmd_i        (cmd_i),
    .slot_index_i (slot_index_i),
    .in_stall_o   (in_stall_o),
    .room_i       (room),
    .res_load_o   (res_load),
    .res_o        (res_d)
  );

  // Output register: load on a finished transaction, drop valid once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign slot_o       = res_q.slot;
  assign generation_o = res_q.generation;
  assign address_o    = res_q.address;
  assign full_res_o   = res_q.full_res;
  assign bad_free_o   = res_q.bad_free;
  assign used_count_o = res_q.used_count;

  // A result never overwrites one the receiver has not taken.
  a_load_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded into an occupied output register");

  // A granted slot or a good free always carries a live generation.
  a_gen_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !full_res_o && !bad_free_o) |-> (generation_o != '0))
    else $error("successful transaction reported generation zero");

  // The block stays busy in the cycle after taking a transaction.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // Full and bad free belong to different commands and never coincide.
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> !(res_d.full_res && res_d.bad_free))
    else $error("full and bad free flagged together");

endmodule

[sim/tb_pool_slot_allocator.sv]
// ----------------------------------------------------------------------------
// tb_pool_slot_allocator - self-checking testbench of the pool slot allocator
// Drives allocate and free transactions through the valid/stall input, tracks
// free marks, generations, search origin and used count in a local copy of
// the pool, and compares every result transaction field by field. Covers
// directed corner cases, generation wrap, and random traffic under three
// idling profiles plus one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_pool_slot_allocator;
  import psa_pkg::*;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned SETTLE_CYC = 16;   // worst allocate latency plus margin
  localparam int unsigned CHUNK_OPS  = 160;

  // clock, reset and block ports
  logic                clk_i;
  logic                rst_ni       = 1'b0;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic                cmd_i        = CMD_ALLOC;
  logic [SLOT_W-1:0]   slot_index_i = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [SLOT_W-1:0]   slot_o;
  logic [GEN_W-1:0]    generation_o;
  logic [ADDR_W-1:0]   address_o;
  logic                full_res_o;
  logic                bad_free_o;
  logic [CNT_W-1:0]    used_count_o;

  // shadow copy of the pool and its registers
  logic [IDX_W-1:0]    shadow_slots;
  logic [EB_W-1:0]     shadow_entry;
  logic [ADDR_W-1:0]   shadow_base;
  bit                  slot_is_free [DEPTH];
  logic [GEN_W-1:0]    slot_gen     [DEPTH];
  int unsigned         last_given;
  logic [CNT_W-1:0]    live_count;

  res_t                pending_results [$];
  int                  fail_count = 0;

  // idling knobs, percent of cycles; hold_left forces a long receiver stall
  int                  gap_pct   = 0;
  int                  stall_pct = 0;
  int                  hold_left = 0;
  int                  alloc_pct = 60;

  pool_slot_allocator #(.POOL_SLOTS(DEPTH)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .slot_index_i (slot_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .slot_o       (slot_o),
    .generation_o (generation_o),
    .address_o    (address_o),
    .full_res_o   (full_res_o),
    .bad_free_o   (bad_free_o),
    .used_count_o (used_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop: far above the slowest legal run.
  initial begin
    #1000000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow pool
  // --------------------------------------------------------------------------
  task automatic shadow_reset();
    shadow_slots = SLOTS_RESET;
    shadow_entry = ENTRY_RESET;
    shadow_base  = BASE_RESET;
    for (int s = 0; s < DEPTH; s++) begin
      slot_is_free[s] = 1'b1;
      slot_gen[s]     = '0;
    end
    last_given = 255;
    live_count = '0;
  endtask

  // Effective search width: zero behaves as one, oversize clamps to depth.
  function automatic int unsigned searched_slots();
    if (shadow_slots == 0) return 1;
    if (shadow_slots > DEPTH) return DEPTH;
    return shadow_slots;
  endfunction

  function automatic logic [ADDR_W-1:0] slot_byte_addr(input int unsigned s);
    return shadow_base + ADDR_W'(s) * ADDR_W'(shadow_entry);
  endfunction

  // Apply one accepted command to the shadow pool and return its result.
  function automatic res_t pool_outcome(input logic op, input logic [SLOT_W-1:0] idx);
    res_t        r;
    int unsigned n;
    int unsigned origin;
    int unsigned s;
    bit          found;
    logic [GEN_W-1:0] g;
    r     = '0;
    n     = searched_slots();
    found = 1'b0;
    if (op == CMD_ALLOC) begin
      // resume just past the last slot handed out; restart at zero if stale
      origin = (last_given < n) ? last_given + 1 : 0;
      if (origin >= n) origin = 0;
      for (int i = 0; i < n && !found; i++) begin
        s = origin + i;
        if (s >= n) s -= n;
        if (slot_is_free[s]) begin
          g = slot_gen[s] + 1'b1;
          if (g <= 1) g = 1;           // skip zero on wrap
          slot_is_free[s] = 1'b0;
          slot_gen[s]     = g;
          if (live_count != COUNT_MAX) live_count++;
          last_given   = s;
          r.slot       = SLOT_W'(s);
          r.generation = g;
          r.address    = slot_byte_addr(s);
          found        = 1'b1;
        end
      end
      r.full_res = !found;
    end else begin
      r.slot       = idx;
      r.address    = slot_byte_addr(idx);
      r.generation = slot_gen[idx];
      if (idx >= n || slot_is_free[idx]) begin
        r.bad_free = 1'b1;
      end else begin
        slot_is_free[idx] = 1'b1;
        if (live_count != 0) live_count--;
      end
    end
    r.used_count = live_count;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Offer one command; predict its result at the edge that accepts it.
  task automatic send_command(input logic op, input logic [SLOT_W-1:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    cmd_i        <= op;
    slot_index_i <= idx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(pool_outcome(op, idx));
  endtask

  // Drop valid and wait until every result is back and the block is quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SLOTS: shadow_slots = data[IDX_W-1:0];
      REG_ENTRY: shadow_entry = data[EB_W-1:0];
      REG_BASE:  shadow_base  = data[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  // Only call with the block idle.
  task automatic program_pool(input int unsigned slots, input int unsigned entry,
                              input logic [ADDR_W-1:0] base);
    reg_write(REG_SLOTS, PDATA_W'(slots));
    reg_write(REG_ENTRY, PDATA_W'(entry));
    reg_write(REG_BASE, base);
  endtask

  // Pick a random allocated slot inside the searched range.
  function automatic bit pick_live_slot(output logic [SLOT_W-1:0] idx);
    int unsigned n;
    int unsigned live;
    int unsigned k;
    n    = searched_slots();
    live = 0;
    idx  = '0;
    for (int s = 0; s < n; s++) if (!slot_is_free[s]) live++;
    if (live == 0) return 1'b0;
    k = $urandom_range(live - 1);
    for (int s = 0; s < n; s++) begin
      if (!slot_is_free[s]) begin
        if (k == 0) begin
          idx = SLOT_W'(s);
          return 1'b1;
        end
        k--;
      end
    end
    return 1'b0;
  endfunction

  // Mostly well-formed traffic (allocate, or free a live slot), some noise.
  task automatic send_random_command();
    logic [SLOT_W-1:0] idx;
    if ($urandom_range(99) < 10) begin
      send_command(CMD_FREE, SLOT_W'($urandom));
    end else if ($urandom_range(99) < alloc_pct || !pick_live_slot(idx)) begin
      send_command(CMD_ALLOC, SLOT_W'($urandom));
    end else begin
      send_command(CMD_FREE, idx);
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver and result checker
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing outstanding: slot 0x%0h", slot_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("slot", 32'(want.slot), 32'(slot_o));
        check_field("generation", 32'(want.generation), 32'(generation_o));
        check_field("address", want.address, address_o);
        check_field("full_res", 32'(want.full_res), 32'(full_res_o));
        check_field("bad_free", 32'(want.bad_free), 32'(bad_free_o));
        check_field("used_count", 32'(want.used_count), 32'(used_count_o));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Corner cases: next-fit order, double free, out-of-range free, stale
  // search origin, full pool, zero and oversize slot counts, address wrap.
  task automatic test_directed();
    send_command(CMD_ALLOC, 8'hFF);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_ALLOC, 8'h5A);
    send_command(CMD_FREE, 8'd1);
    send_command(CMD_FREE, 8'd1);      // already free
    send_command(CMD_ALLOC, 8'hA5);    // next fit skips the hole at slot 1
    send_command(CMD_FREE, 8'd200);    // never allocated
    wait_drained();
    // shrink below the search origin, max entry size, base near the top
    program_pool(2, 16'hFFFF, 32'hFFFF_FFFF);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_ALLOC, 8'h00);    // pool now full
    send_command(CMD_FREE, 8'd3);      // live but beyond the searched range
    send_command(CMD_FREE, 8'd0);
    wait_drained();
    // zero slot count acts as one; zero entry size
    program_pool(0, 0, 32'h1234_5678);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_FREE, 8'd1);
    wait_drained();
    // oversize slot count clamps to depth
    program_pool(511, 1, 32'h0);
    send_command(CMD_ALLOC, 8'h00);
    send_command(CMD_FREE, 8'hFF);
    send_command(CMD_FREE, 8'd4);
    send_command(CMD_ALLOC, 8'h00);
    wait_drained();
  endtask

  // One slot, cycled until its generation wraps past the top value.
  task automatic test_generation_wrap();
    program_pool(1, 16'h0040, 32'h8000_0000);
    for (int i = 0; i < 280; i++) begin
      if ($urandom_range(99) < 8) send_command(1'($urandom_range(1)), SLOT_W'($urandom));
      else if (slot_is_free[0]) send_command(CMD_ALLOC, SLOT_W'($urandom));
      else send_command(CMD_FREE, 8'd0);
    end
    wait_drained();
  endtask

  // Random traffic in chunks, each with a fresh register setting.
  task automatic test_random_traffic(input int chunks, input bit with_hold_off);
    int unsigned      slots;
    int unsigned      entry;
    logic [ADDR_W-1:0] base;
    for (int c = 0; c < chunks; c++) begin
      case ($urandom_range(9))
        0:       slots = 1;
        1:       slots = 256;
        2:       slots = 0;
        3:       slots = $urandom_range(257, 511);
        4, 5, 6: slots = $urandom_range(2, 16);
        default: slots = $urandom_range(17, 255);
      endcase
      case ($urandom_range(5))
        0:       entry = 1;
        1:       entry = 16'hFFFF;
        2:       entry = 0;
        default: entry = $urandom_range(65535);
      endcase
      case ($urandom_range(3))
        0:       base = '0;
        1:       base = '1;
        default: base = $urandom;
      endcase
      program_pool(slots, entry, base);
      alloc_pct = $urandom_range(35, 85);
      // hold the receiver off so the block fills and stalls its input
      if (with_hold_off && c == 0) hold_left = 400;
      for (int i = 0; i < CHUNK_OPS; i++) send_random_command();
      wait_drained();
    end
  endtask

  initial begin
    shadow_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender idles rarely, receiver mostly stalls
    gap_pct   = 24;
    stall_pct = 85;
    test_directed();
    test_generation_wrap();
    test_random_traffic(4, 1'b0);

    // sender idles mostly, receiver rarely stalls
    gap_pct   = 85;
    stall_pct = 24;
    test_random_traffic(4, 1'b0);

    // back to back, with one long receiver hold-off
    gap_pct   = 0;
    stall_pct = 0;
    test_random_traffic(4, 1'b1);

    wait_drained();
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
